>>> rtl/core/ncss_pkg.sv
// shared types, constants and saturating helpers for the clock sync servo
`default_nettype none

package ncss_pkg;

   localparam int RECORDS_DEFAULT = 1024;

   localparam int TIME_W      = 64;
   localparam int RATE_W      = 32;
   localparam int LIMIT_W     = 31;
   localparam int REG_W       = 32;
   localparam int REC_COUNT_W = 11;
   localparam int CSR_IDX_W   = 3;
   localparam int DIV_W       = 96;
   localparam int DIV_STEPS   = 96;
   localparam int FRAC_W      = 24;

   typedef logic signed [TIME_W-1:0] time_type;
   typedef logic signed [RATE_W-1:0] rate_type;
   typedef logic [1:0]               cmd_type;

   typedef struct packed {
      logic              neg;
      logic [TIME_W-1:0] mag;
   } mdiff_type;

   localparam cmd_type CMD_CLEAR  = 2'd0;
   localparam cmd_type CMD_SAMPLE = 2'd1;
   localparam cmd_type CMD_UPDATE = 2'd2;
   localparam cmd_type CMD_STEP   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_TIME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_JUMP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE    = 3'd4;

   localparam logic [REG_W-1:0]   FILTER_TIME_RST = 32'd10000000;
   localparam logic [REG_W-1:0]   MAX_AGE_RST     = 32'd120000000;
   localparam logic [REG_W-1:0]   MAX_JUMP_RST    = 32'd2345678;
   localparam logic [LIMIT_W-1:0] MIN_RATE_RST    = 31'd8388608;
   localparam logic [LIMIT_W-1:0] MAX_RATE_RST    = 31'd33554432;

   localparam rate_type RATE_ONE = 32'sd16777216;
   localparam rate_type RATE_MAX = 32'sh7FFF_FFFF;
   localparam rate_type RATE_MIN = 32'sh8000_0000;
   localparam time_type TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam time_type TIME_MIN = 64'sh8000_0000_0000_0000;

   function automatic time_type sat_add(time_type a, time_type b);
      logic signed [TIME_W:0] s;
      s = {a[TIME_W-1], a} + {b[TIME_W-1], b};
      if (s[TIME_W] != s[TIME_W-1]) return s[TIME_W] ? TIME_MIN : TIME_MAX;
      return s[TIME_W-1:0];
   endfunction

   function automatic time_type sat_sub(time_type a, time_type b);
      logic signed [TIME_W:0] s;
      s = {a[TIME_W-1], a} - {b[TIME_W-1], b};
      if (s[TIME_W] != s[TIME_W-1]) return s[TIME_W] ? TIME_MIN : TIME_MAX;
      return s[TIME_W-1:0];
   endfunction

   function automatic mdiff_type mag_diff(time_type a, time_type b);
      logic signed [TIME_W:0] s;
      logic signed [TIME_W:0] n;
      mdiff_type r;
      s = {a[TIME_W-1], a} - {b[TIME_W-1], b};
      n = -s;
      r.neg = s[TIME_W];
      r.mag = s[TIME_W] ? n[TIME_W-1:0] : s[TIME_W-1:0];
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] mag_of(time_type v);
      return v[TIME_W-1] ? (TIME_W'(0) - v) : v;
   endfunction

   function automatic time_type from_mag(logic [TIME_W-1:0] m, logic neg);
      if (!neg) return m[TIME_W-1] ? TIME_MAX : m;
      if (m[TIME_W-1]) return TIME_MIN;
      return TIME_W'(0) - m;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/ncss_req_if.sv
// command channel: command code with remote and local time
`default_nettype none

interface ncss_req_if;
   import ncss_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  cmd;
   time_type remote_time;
   time_type local_time;

   modport source (output valid, cmd, remote_time, local_time, input ready);
   modport sink   (input valid, cmd, remote_time, local_time, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ncss_rsp_if.sv
// result channel: time estimate, rate, record count and resync flag
`default_nettype none

interface ncss_rsp_if;
   import ncss_pkg::*;

   logic                   valid;
   logic                   ready;
   time_type               step_time;
   rate_type               rate;
   logic [REC_COUNT_W-1:0] record_count;
   logic                   resynced;

   modport source (output valid, step_time, rate, record_count, resynced, input ready);
   modport sink   (input valid, step_time, rate, record_count, resynced, output ready);
endinterface

`default_nettype wire

>>> rtl/core/network_clock_sync_servo_unit.sv
// Network clock sync servo: one command in flight at a time. The time pairs live in two
// synchronous ring memories (remote and local) read one entry per cycle. Clear and a
// step with no records go straight to the result; a sample writes the new pair, then
// reads the oldest entry and ages it out while its local time lies the max age or more
// behind, until the ring empties. An update with no records or with one record resyncs;
// with two or more, the 96-step shift-subtract divider forms the Q8.24 rate, unless the
// newest and oldest local times are equal. A step with records makes passes of a shared
// 64x32 multiplier for the long and short predictions and, unless the blend falls back
// to one half, a third pass and the same divider for the blend. A new command is
// accepted in the cycle after the previous result is registered; the result register
// holds its beat while the next command runs. Ring entries are not cleared after reset
// and need no clearing pass.
`default_nettype none

module network_clock_sync_servo_unit #(
   parameter int MAX_RECORDS = ncss_pkg::RECORDS_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   ncss_req_if.sink                        req_chan,
   ncss_rsp_if.source                      rsp_chan,
   input  wire                             csr_wr_en,
   input  wire  [ncss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [ncss_pkg::REG_W-1:0]      csr_wr_data
);
   import ncss_pkg::*;

   localparam int IW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int OW = CW + 1;
   localparam int DCW = $clog2(DIV_STEPS + 1);

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_AGE_RD    = 5'd1;
   localparam logic [4:0] S_AGE_CHK   = 5'd2;
   localparam logic [4:0] S_UPD_ONE   = 5'd3;
   localparam logic [4:0] S_UPD_NEW   = 5'd4;
   localparam logic [4:0] S_UPD_OLD   = 5'd5;
   localparam logic [4:0] S_UPD_CHK   = 5'd6;
   localparam logic [4:0] S_STEP0     = 5'd7;
   localparam logic [4:0] S_MUL_LO    = 5'd8;
   localparam logic [4:0] S_MUL_HI    = 5'd9;
   localparam logic [4:0] S_MUL_FIN   = 5'd10;
   localparam logic [4:0] S_ACC       = 5'd11;
   localparam logic [4:0] S_BLEND0    = 5'd12;
   localparam logic [4:0] S_BLEND1    = 5'd13;
   localparam logic [4:0] S_DIV       = 5'd14;
   localparam logic [4:0] S_DIV_END   = 5'd15;
   localparam logic [4:0] S_BLEND_END = 5'd16;
   localparam logic [4:0] S_FIN       = 5'd17;

   localparam logic [1:0] PH_LONG  = 2'd0;
   localparam logic [1:0] PH_SHORT = 2'd1;
   localparam logic [1:0] PH_BLEND = 2'd2;

   // architectural state
   logic [4:0]         state_ff, state_in;
   logic [IW-1:0]      newest_ff, newest_in;
   logic [CW-1:0]      count_ff, count_in;
   rate_type           rate_ff, rate_in;
   time_type           anc_rem_ff, anc_rem_in;
   time_type           anc_loc_ff, anc_loc_in;
   time_type           est_ff, est_in;
   time_type           prev_ff, prev_in;
   logic               resync_ff, resync_in;
   logic [REG_W-1:0]   filt_ff, age_ff, jump_ff;
   logic [LIMIT_W-1:0] minr_ff, maxr_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   // working registers
   cmd_type            cmd_ff, cmd_in;
   time_type           loc_ff, loc_in;
   time_type           nr_ff, nr_in, nl_ff, nl_in;
   time_type           longp_ff, longp_in, shortp_ff, shortp_in;
   time_type           skip_ff, skip_in, mr_ff, mr_in, diff_ff, diff_in, bl_ff, bl_in;
   logic [TIME_W-1:0]  mul_a_ff, mul_a_in;
   logic [REG_W-1:0]   mul_b_ff, mul_b_in;
   logic               neg_ff, neg_in;
   logic [1:0]         phase_ff, phase_in;
   logic [TIME_W-1:0]  prod_ff, prod_in, lo_ff, lo_in;
   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [TIME_W-1:0]  dvs_ff, dvs_in, rem_ff, rem_in;
   logic [DCW-1:0]     div_cnt_ff, div_cnt_in;
   time_type           rsp_time_ff;
   rate_type           rsp_rate_ff;
   logic [REC_COUNT_W-1:0] rsp_count_ff;
   logic               rsp_resync_ff;

   // ring memories
   time_type           ring_rem_mem [MAX_RECORDS];
   time_type           ring_loc_mem [MAX_RECORDS];
   time_type           mem_rem_ff, mem_loc_ff;
   logic               mem_we;
   logic [IW-1:0]      mem_wa, mem_ra;
   time_type           mem_wd_rem, mem_wd_loc;

   // combinational helpers
   logic [OW-1:0]      oldest_sum;
   logic [IW-1:0]      oldest_idx;
   logic [IW-1:0]      newest_next;
   logic [REG_W-1:0]   mul_x;
   logic [TIME_W-1:0]  mul_p;
   logic [TIME_W:0]    div_r2, div_sub;
   logic               div_ge;
   logic [TIME_W-1:0]  mr_mag;
   logic [DIV_W-1:0]   blend_prod;
   logic signed [TIME_W:0] age_diff;
   mdiff_type          md_rem, md_loc, md_jump;
   time_type           d_anchor;
   logic               req_fire, out_free;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign oldest_sum = OW'(newest_ff) + OW'(MAX_RECORDS + 1) - OW'(count_ff);
   assign oldest_idx = (oldest_sum >= OW'(MAX_RECORDS)) ?
                       IW'(oldest_sum - OW'(MAX_RECORDS)) : IW'(oldest_sum);
   assign newest_next = (newest_ff == IW'(MAX_RECORDS - 1)) ? '0 : newest_ff + 1'b1;

   assign mem_ra = (state_ff == S_AGE_RD || state_ff == S_UPD_NEW) ? oldest_idx : newest_ff;

   assign mul_x = (state_ff == S_MUL_LO) ? mul_a_ff[REG_W-1:0] : mul_a_ff[TIME_W-1:REG_W];
   assign mul_p = TIME_W'(mul_x) * TIME_W'(mul_b_ff);

   assign div_r2  = {rem_ff, dvd_ff[DIV_W-1]};
   assign div_ge  = div_r2 >= {1'b0, dvs_ff};
   assign div_sub = div_r2 - {1'b0, dvs_ff};

   assign mr_mag     = (prod_ff << 8) + (lo_ff >> FRAC_W);
   assign blend_prod = {prod_ff, 32'd0} + {32'd0, lo_ff};
   assign age_diff   = {loc_ff[TIME_W-1], loc_ff} - {mem_loc_ff[TIME_W-1], mem_loc_ff};
   assign md_rem     = mag_diff(nr_ff, mem_rem_ff);
   assign md_loc     = mag_diff(nl_ff, mem_loc_ff);
   assign md_jump    = mag_diff(est_ff, nr_ff);
   assign d_anchor   = sat_sub(loc_ff, anc_loc_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_rem_mem[mem_wa] <= mem_wd_rem;
         ring_loc_mem[mem_wa] <= mem_wd_loc;
      end
      mem_rem_ff <= ring_rem_mem[mem_ra];
      mem_loc_ff <= ring_loc_mem[mem_ra];
   end

   always_comb begin
      state_in     = state_ff;
      newest_in    = newest_ff;
      count_in     = count_ff;
      rate_in      = rate_ff;
      anc_rem_in   = anc_rem_ff;
      anc_loc_in   = anc_loc_ff;
      est_in       = est_ff;
      prev_in      = prev_ff;
      resync_in    = resync_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_in       = cmd_ff;
      loc_in       = loc_ff;
      nr_in        = nr_ff;
      nl_in        = nl_ff;
      longp_in     = longp_ff;
      shortp_in    = shortp_ff;
      skip_in      = skip_ff;
      mr_in        = mr_ff;
      diff_in      = diff_ff;
      bl_in        = bl_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      neg_in       = neg_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      lo_in        = lo_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      mem_we       = 1'b0;
      mem_wa       = newest_ff;
      mem_wd_rem   = req_chan.remote_time;
      mem_wd_loc   = req_chan.local_time;

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_chan.cmd;
               loc_in    = req_chan.local_time;
               resync_in = 1'b0;
               unique case (req_chan.cmd)
                  CMD_CLEAR: begin
                     count_in   = '0;
                     rate_in    = RATE_ONE;
                     anc_rem_in = '0;
                     anc_loc_in = '0;
                     est_in     = '0;
                     state_in   = S_FIN;
                  end
                  CMD_SAMPLE: begin
                     newest_in = newest_next;
                     mem_we    = 1'b1;
                     mem_wa    = newest_next;
                     if (count_ff != CW'(MAX_RECORDS)) count_in = count_ff + 1'b1;
                     state_in  = S_AGE_RD;
                  end
                  CMD_UPDATE: begin
                     if (count_ff == '0) begin
                        mem_we     = 1'b1;
                        mem_wd_rem = '0;
                        mem_wd_loc = '0;
                        rate_in    = RATE_ONE;
                        anc_rem_in = '0;
                        anc_loc_in = '0;
                        est_in     = '0;
                        count_in   = CW'(1);
                        resync_in  = 1'b1;
                        state_in   = S_FIN;
                     end else if (count_ff == CW'(1)) begin
                        state_in = S_UPD_ONE;
                     end else begin
                        state_in = S_UPD_NEW;
                     end
                  end
                  CMD_STEP: begin
                     if (count_ff == '0) begin
                        est_in   = req_chan.local_time;
                        prev_in  = req_chan.local_time;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_STEP0;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_AGE_RD: begin
            state_in = (count_ff == '0) ? S_FIN : S_AGE_CHK;
         end
         S_AGE_CHK: begin
            if (age_diff >= $signed({33'd0, age_ff})) begin
               count_in = count_ff - 1'b1;
               state_in = S_AGE_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_UPD_ONE: begin
            rate_in    = RATE_ONE;
            anc_rem_in = mem_rem_ff;
            anc_loc_in = mem_loc_ff;
            est_in     = mem_rem_ff;
            count_in   = CW'(1);
            resync_in  = 1'b1;
            state_in   = S_FIN;
         end
         S_UPD_NEW: begin
            nr_in    = mem_rem_ff;
            nl_in    = mem_loc_ff;
            state_in = S_UPD_OLD;
         end
         S_UPD_OLD: begin
            if (md_loc.mag != '0) begin
               dvd_in     = {8'd0, md_rem.mag, 24'd0};
               dvs_in     = md_loc.mag;
               rem_in     = '0;
               div_cnt_in = DCW'(DIV_STEPS);
               neg_in     = md_rem.neg ^ md_loc.neg;
               state_in   = S_DIV;
            end else begin
               state_in = S_UPD_CHK;
            end
         end
         S_UPD_CHK: begin
            if (md_jump.mag > {32'd0, jump_ff} ||
                $signed({rate_ff[RATE_W-1], rate_ff}) < $signed({2'b00, minr_ff}) ||
                $signed({rate_ff[RATE_W-1], rate_ff}) > $signed({2'b00, maxr_ff})) begin
               rate_in    = RATE_ONE;
               anc_rem_in = nr_ff;
               anc_loc_in = nl_ff;
               est_in     = nr_ff;
               count_in   = CW'(1);
               resync_in  = 1'b1;
            end
            state_in = S_FIN;
         end
         S_STEP0: begin
            mul_a_in = mag_of(d_anchor);
            mul_b_in = rate_ff[RATE_W-1] ? REG_W'(0) - rate_ff : rate_ff;
            neg_in   = d_anchor[TIME_W-1] ^ rate_ff[RATE_W-1];
            skip_in  = sat_sub(loc_ff, prev_ff);
            phase_in = PH_LONG;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_in  = mul_p;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            lo_in    = prod_ff;
            prod_in  = mul_p;
            state_in = S_MUL_FIN;
         end
         S_MUL_FIN: begin
            if (phase_ff == PH_BLEND) begin
               dvd_in     = blend_prod;
               dvs_in     = {32'd0, filt_ff};
               rem_in     = '0;
               div_cnt_in = DCW'(DIV_STEPS);
               state_in   = S_DIV;
            end else begin
               if (prod_ff[TIME_W-1:55] != '0) mr_in = neg_ff ? TIME_MIN : TIME_MAX;
               else mr_in = from_mag(mr_mag, neg_ff);
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (phase_ff == PH_LONG) begin
               longp_in = sat_add(anc_rem_ff, mr_ff);
               mul_a_in = mag_of(skip_ff);
               neg_in   = skip_ff[TIME_W-1] ^ rate_ff[RATE_W-1];
               phase_in = PH_SHORT;
               state_in = S_MUL_LO;
            end else begin
               shortp_in = sat_add(est_ff, mr_ff);
               state_in  = S_BLEND0;
            end
         end
         S_BLEND0: begin
            diff_in  = sat_sub(longp_ff, shortp_ff);
            state_in = S_BLEND1;
         end
         S_BLEND1: begin
            neg_in = diff_ff[TIME_W-1];
            if (skip_ff > 0 && skip_ff < $signed({32'd0, filt_ff})) begin
               mul_a_in = mag_of(diff_ff);
               mul_b_in = skip_ff[REG_W-1:0];
               phase_in = PH_BLEND;
               state_in = S_MUL_LO;
            end else begin
               bl_in    = from_mag(mag_of(diff_ff) >> 1, diff_ff[TIME_W-1]);
               state_in = S_BLEND_END;
            end
         end
         S_DIV: begin
            rem_in     = div_ge ? div_sub[TIME_W-1:0] : div_r2[TIME_W-1:0];
            dvd_in     = {dvd_ff[DIV_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == DCW'(1)) state_in = S_DIV_END;
         end
         S_DIV_END: begin
            if (cmd_ff == CMD_UPDATE) begin
               if (dvd_ff[DIV_W-1:31] != '0) rate_in = neg_ff ? RATE_MIN : RATE_MAX;
               else if (neg_ff) rate_in = RATE_W'(0) - {1'b0, dvd_ff[30:0]};
               else rate_in = {1'b0, dvd_ff[30:0]};
               anc_rem_in = nr_ff;
               anc_loc_in = nl_ff;
               state_in   = S_UPD_CHK;
            end else begin
               bl_in    = from_mag(dvd_ff[TIME_W-1:0], neg_ff);
               state_in = S_BLEND_END;
            end
         end
         S_BLEND_END: begin
            est_in   = sat_add(shortp_ff, bl_ff);
            prev_in  = loc_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         newest_ff    <= '0;
         count_ff     <= '0;
         rate_ff      <= RATE_ONE;
         anc_rem_ff   <= '0;
         anc_loc_ff   <= '0;
         est_ff       <= '0;
         prev_ff      <= '0;
         resync_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         filt_ff      <= FILTER_TIME_RST;
         age_ff       <= MAX_AGE_RST;
         jump_ff      <= MAX_JUMP_RST;
         minr_ff      <= MIN_RATE_RST;
         maxr_ff      <= MAX_RATE_RST;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         count_ff     <= count_in;
         rate_ff      <= rate_in;
         anc_rem_ff   <= anc_rem_in;
         anc_loc_ff   <= anc_loc_in;
         est_ff       <= est_in;
         prev_ff      <= prev_in;
         resync_ff    <= resync_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FILTER_TIME: filt_ff <= csr_wr_data;
               CSR_MAX_AGE:     age_ff  <= csr_wr_data;
               CSR_MAX_JUMP:    jump_ff <= csr_wr_data;
               CSR_MIN_RATE:    minr_ff <= csr_wr_data[LIMIT_W-1:0];
               CSR_MAX_RATE:    maxr_ff <= csr_wr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      loc_ff     <= loc_in;
      nr_ff      <= nr_in;
      nl_ff      <= nl_in;
      longp_ff   <= longp_in;
      shortp_ff  <= shortp_in;
      skip_ff    <= skip_in;
      mr_ff      <= mr_in;
      diff_ff    <= diff_in;
      bl_ff      <= bl_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      neg_ff     <= neg_in;
      phase_ff   <= phase_in;
      prod_ff    <= prod_in;
      lo_ff      <= lo_in;
      dvd_ff     <= dvd_in;
      dvs_ff     <= dvs_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      if (state_ff == S_FIN && out_free) begin
         rsp_time_ff   <= est_ff;
         rsp_rate_ff   <= rate_ff;
         rsp_count_ff  <= REC_COUNT_W'(count_ff);
         rsp_resync_ff <= resync_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.step_time    = rsp_time_ff;
   assign rsp_chan.rate         = rsp_rate_ff;
   assign rsp_chan.record_count = rsp_count_ff;
   assign rsp_chan.resynced     = rsp_resync_ff;

endmodule

`default_nettype wire

>>> tb/sv/network_clock_sync_servo_unit_tb.sv
// testbench for the clock sync servo: table-driven directed beats, then random sessions
`timescale 1ns / 100ps

module network_clock_sync_servo_unit_tb;
   import ncss_pkg::*;

   localparam int RING_DEPTH  = 1024;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 3000;
   localparam int RAND_ITEMS  = 105;

   typedef struct packed {
      time_type               step_time;
      rate_type               rate;
      logic [REC_COUNT_W-1:0] record_count;
      logic                   resynced;
   } servo_beat_t;

   typedef struct packed {
      cmd_type     cmd;
      time_type    remote_time;
      time_type    local_time;
      logic        typed;
      servo_beat_t beat;
   } table_row_t;

   localparam int ROWS = 25;
   localparam table_row_t DIRECTED [ROWS] = '{
      '{CMD_STEP,   64'sd0, 64'sd123, 1'b1, '{64'sd123, RATE_ONE, 11'd0, 1'b0}},
      '{CMD_UPDATE, 64'sd0, 64'sd0, 1'b1, '{64'sd0, RATE_ONE, 11'd1, 1'b1}},
      '{CMD_CLEAR,  64'sd0, 64'sd0, 1'b1, '{64'sd0, RATE_ONE, 11'd0, 1'b0}},
      '{CMD_SAMPLE, 64'sd1000, 64'sd1000, 1'b1, '{64'sd0, RATE_ONE, 11'd1, 1'b0}},
      '{CMD_UPDATE, 64'sd0, 64'sd0, 1'b1, '{64'sd1000, RATE_ONE, 11'd1, 1'b1}},
      '{CMD_SAMPLE, 64'sd2000000, 64'sd2000000, 1'b0, '0},
      '{CMD_UPDATE, 64'sd0, 64'sd0, 1'b0, '0},
      '{CMD_STEP,   64'sd0, 64'sd2500000, 1'b0, '0},
      '{CMD_STEP,   64'sd0, 64'sd2500000, 1'b0, '0},
      '{CMD_SAMPLE, 64'sd3000000, 64'sd2000000, 1'b0, '0},
      '{CMD_CLEAR,  64'sd0, 64'sd0, 1'b1, '{64'sd0, RATE_ONE, 11'd0, 1'b0}},
      '{CMD_SAMPLE, 64'sd5, 64'sd7, 1'b0, '0},
      '{CMD_SAMPLE, 64'sd9, 64'sd7, 1'b0, '0},
      '{CMD_UPDATE, 64'sd0, 64'sd0, 1'b0, '0},
      '{CMD_SAMPLE, TIME_MAX, TIME_MIN, 1'b0, '0},
      '{CMD_SAMPLE, TIME_MIN, TIME_MAX, 1'b0, '0},
      '{CMD_UPDATE, 64'sd0, 64'sd0, 1'b0, '0},
      '{CMD_STEP,   64'sd0, TIME_MIN, 1'b0, '0},
      '{CMD_STEP,   64'sd0, TIME_MAX, 1'b0, '0},
      '{CMD_SAMPLE, 64'sd0, -64'sd1, 1'b0, '0},
      '{CMD_SAMPLE, -64'sd5000000, 64'sd5000000, 1'b0, '0},
      '{CMD_UPDATE, -64'sd1, -64'sd1, 1'b0, '0},
      '{CMD_STEP,   -64'sd1, 64'sd0, 1'b0, '0},
      '{CMD_CLEAR,  -64'sd1, -64'sd1, 1'b1, '{64'sd0, RATE_ONE, 11'd0, 1'b0}},
      '{CMD_UPDATE, 64'sd0, 64'sd0, 1'b1, '{64'sd0, RATE_ONE, 11'd1, 1'b1}}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0] csr_wr_data;

   ncss_req_if req ();
   ncss_rsp_if rsp ();

   network_clock_sync_servo_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // servo mirror
   logic [REG_W-1:0]   m_filter, m_max_age, m_max_jump;
   logic [LIMIT_W-1:0] m_min_rate, m_max_rate;
   time_type           m_ring_remote [RING_DEPTH];
   time_type           m_ring_local [RING_DEPTH];
   int                 m_newest, m_count;
   rate_type           m_rate;
   time_type           m_anchor_remote, m_anchor_local, m_estimate, m_last_step_local;

   servo_beat_t due_beats[$];
   int          errors;
   int          cycles;
   int          burst_left;
   bit          hold_request;
   int          hold_left;
   int          seg_left;
   int          seg_mode;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic time_type clip_sum(logic signed [TIME_W:0] s);
      if (s > $signed({1'b0, TIME_MAX})) return TIME_MAX;
      if (s < $signed({1'b1, TIME_MIN})) return TIME_MIN;
      return s[TIME_W-1:0];
   endfunction

   function automatic time_type add_clip(time_type a, time_type b);
      return clip_sum({a[TIME_W-1], a} + {b[TIME_W-1], b});
   endfunction

   function automatic time_type sub_clip(time_type a, time_type b);
      return clip_sum({a[TIME_W-1], a} - {b[TIME_W-1], b});
   endfunction

   function automatic logic [TIME_W-1:0] span(time_type a, time_type b, output logic neg);
      logic signed [TIME_W:0] s;
      s = {a[TIME_W-1], a} - {b[TIME_W-1], b};
      neg = s[TIME_W];
      return neg ? TIME_W'(-s) : s[TIME_W-1:0];
   endfunction

   function automatic time_type signed_of(logic [TIME_W-1:0] m, logic neg);
      if (!neg) return m[TIME_W-1] ? TIME_MAX : $signed(m);
      if (m[TIME_W-1]) return TIME_MIN;
      return $signed(-m);
   endfunction

   function automatic logic [TIME_W-1:0] abs_time(time_type v);
      return v[TIME_W-1] ? TIME_W'(-v) : v;
   endfunction

   function automatic rate_type rate_quot(logic [TIME_W-1:0] n, logic [TIME_W-1:0] d,
                                          logic neg);
      logic [TIME_W+FRAC_W-1:0] q;
      if (n / d >= 128) return neg ? RATE_MIN : RATE_MAX;
      q = {n, {FRAC_W{1'b0}}} / d;
      return neg ? -$signed(q[RATE_W-1:0]) : $signed(q[RATE_W-1:0]);
   endfunction

   function automatic time_type rate_scale(time_type delta, rate_type r);
      logic [63:0] dm, rm, hi, lo;
      logic neg;
      dm = abs_time(delta);
      rm = abs_time(TIME_W'(r));
      neg = delta[TIME_W-1] ^ r[RATE_W-1];
      hi = (dm >> 32) * rm;
      lo = {32'd0, dm[31:0]} * rm;
      if (hi >> 55 != 0) return neg ? TIME_MIN : TIME_MAX;
      return signed_of((hi << 8) + (lo >> 24), neg);
   endfunction

   function automatic time_type blend_share(time_type diff, time_type skip, logic [31:0] f);
      logic [63:0] dm, q;
      logic [127:0] p;
      dm = abs_time(diff);
      if (skip > 0 && skip < $signed({32'd0, f})) begin
         p = {64'd0, dm} * {64'd0, skip};
         p = p / {96'd0, f};
         q = p[63:0];
      end else begin
         q = dm >> 1;
      end
      return signed_of(q, diff[TIME_W-1]);
   endfunction

   function automatic int oldest_slot();
      return (m_newest + RING_DEPTH + 1 - m_count) % RING_DEPTH;
   endfunction

   task automatic resync_to(time_type r, time_type l);
      m_rate = RATE_ONE;
      m_anchor_remote = r;
      m_anchor_local = l;
      m_estimate = r;
      m_ring_remote[m_newest] = r;
      m_ring_local[m_newest] = l;
      m_count = 1;
   endtask

   task automatic advance_servo(cmd_type cmd, time_type r, time_type l,
                                output servo_beat_t beat);
      logic     resynced;
      int       o;
      time_type nr, nl, longp, shortp, skip;
      logic [TIME_W-1:0] nm, dm, jm;
      logic nneg, dneg, jneg;
      resynced = 1'b0;
      case (cmd)
         CMD_CLEAR: begin
            m_count = 0;
            m_rate = RATE_ONE;
            m_anchor_remote = 0;
            m_anchor_local = 0;
            m_estimate = 0;
         end
         CMD_SAMPLE: begin
            m_newest = (m_newest + 1) % RING_DEPTH;
            m_ring_remote[m_newest] = r;
            m_ring_local[m_newest] = l;
            if (m_count < RING_DEPTH) m_count++;
            while (m_count > 0 &&
                   sub_clip(l, m_ring_local[oldest_slot()]) >= $signed({32'd0, m_max_age}))
               m_count--;
         end
         CMD_UPDATE: begin
            if (m_count == 0) begin
               resync_to(0, 0);
               resynced = 1'b1;
            end else if (m_count == 1) begin
               resync_to(m_ring_remote[m_newest], m_ring_local[m_newest]);
               resynced = 1'b1;
            end else begin
               o = oldest_slot();
               nr = m_ring_remote[m_newest];
               nl = m_ring_local[m_newest];
               nm = span(nr, m_ring_remote[o], nneg);
               dm = span(nl, m_ring_local[o], dneg);
               if (dm != 0) begin
                  m_rate = rate_quot(nm, dm, nneg ^ dneg);
                  m_anchor_remote = nr;
                  m_anchor_local = nl;
               end
               jm = span(m_estimate, nr, jneg);
               if (jm > {32'd0, m_max_jump} || m_rate < $signed({1'b0, m_min_rate}) ||
                   m_rate > $signed({1'b0, m_max_rate})) begin
                  resync_to(nr, nl);
                  resynced = 1'b1;
               end
            end
         end
         default: begin
            if (m_count == 0) begin
               m_estimate = l;
            end else begin
               longp = add_clip(m_anchor_remote, rate_scale(sub_clip(l, m_anchor_local), m_rate));
               skip = sub_clip(l, m_last_step_local);
               shortp = add_clip(m_estimate, rate_scale(skip, m_rate));
               m_estimate = add_clip(shortp, blend_share(sub_clip(longp, shortp), skip, m_filter));
            end
            m_last_step_local = l;
         end
      endcase
      beat.step_time = m_estimate;
      beat.rate = m_rate;
      beat.record_count = REC_COUNT_W'(m_count);
      beat.resynced = resynced;
   endtask

   task automatic send_beat(cmd_type cmd, time_type r, time_type l, logic typed,
                            servo_beat_t typed_beat);
      servo_beat_t beat;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.remote_time <= r;
      req.local_time <= l;
      do @(posedge clock); while (!(req.valid && req.ready));
      advance_servo(cmd, r, l, beat);
      due_beats.push_back(typed ? typed_beat : beat);
      burst_left--;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_FILTER_TIME: m_filter = value;
         CSR_MAX_AGE:     m_max_age = value;
         CSR_MAX_JUMP:    m_max_jump = value;
         CSR_MIN_RATE:    m_min_rate = value[LIMIT_W-1:0];
         default:         m_max_rate = value[LIMIT_W-1:0];
      endcase
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic note_error(string what, servo_beat_t want, servo_beat_t got);
      errors++;
      if (errors <= 10)
         $display("%s: want time %0d rate %0d count %0d resync %0d, got %0d %0d %0d %0d",
                  what, want.step_time, want.rate, want.record_count, want.resynced,
                  got.step_time, got.rate, got.record_count, got.resynced);
   endtask

   // result checker
   always @(posedge clock) begin
      servo_beat_t got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.step_time, rsp.rate, rsp.record_count, rsp.resynced};
         if (due_beats.size() == 0) begin
            note_error("unexpected beat", '0, got);
         end else begin
            want = due_beats.pop_front();
            if (got !== want) note_error("beat mismatch", want, got);
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_mode = $urandom_range(0, 2);
            seg_left = $urandom_range(20, 200);
         end
         seg_left--;
         case (seg_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= (cycles % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("network_clock_sync_servo_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      time_type base_l, base_r, lstep, rstep;
      cmd_type  cmd;
      int       pick;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req.valid = 1'b0;
      req.cmd = CMD_CLEAR;
      req.remote_time = '0;
      req.local_time = '0;
      rsp.ready = 1'b0;
      errors = 0;
      cycles = 0;
      burst_left = 0;
      hold_request = 1'b0;
      hold_left = 0;
      seg_left = 0;
      seg_mode = 0;
      m_filter = FILTER_TIME_RST;
      m_max_age = MAX_AGE_RST;
      m_max_jump = MAX_JUMP_RST;
      m_min_rate = MIN_RATE_RST;
      m_max_rate = MAX_RATE_RST;
      m_newest = 0;
      m_count = 0;
      m_rate = RATE_ONE;
      m_anchor_remote = 0;
      m_anchor_local = 0;
      m_estimate = 0;
      m_last_step_local = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i])
         send_beat(DIRECTED[i].cmd, DIRECTED[i].remote_time, DIRECTED[i].local_time,
                   DIRECTED[i].typed, DIRECTED[i].beat);

      for (int phase = 0; phase < 7; phase++) begin
         drain();
         case (phase)
            0: ;
            1: begin
               write_reg(CSR_FILTER_TIME, 32'd1);
               write_reg(CSR_MAX_AGE, 32'hFFFF_FFFF);
               write_reg(CSR_MAX_JUMP, 32'd0);
               write_reg(CSR_MIN_RATE, 32'd0);
               write_reg(CSR_MAX_RATE, 32'hFFFF_FFFF);
            end
            2: begin
               write_reg(CSR_FILTER_TIME, 32'hFFFF_FFFF);
               write_reg(CSR_MAX_AGE, 32'd1);
               write_reg(CSR_MAX_JUMP, 32'hFFFF_FFFF);
               write_reg(CSR_MIN_RATE, 32'h7FFF_FFFF);
               write_reg(CSR_MAX_RATE, 32'h8000_0000);
            end
            3: begin
               write_reg(CSR_FILTER_TIME, 32'd0);
               write_reg(CSR_MAX_AGE, 32'd0);
               write_reg(CSR_MAX_JUMP, 32'd100);
               write_reg(CSR_MIN_RATE, 32'd0);
               write_reg(CSR_MAX_RATE, 32'h7FFF_FFFF);
            end
            default: begin
               write_reg(CSR_FILTER_TIME, $urandom_range(1, 20000000));
               write_reg(CSR_MAX_AGE, $urandom_range(1000000, 200000000));
               write_reg(CSR_MAX_JUMP, $urandom_range(0, 5000000));
               write_reg(CSR_MIN_RATE, {1'($urandom_range(0, 1)),
                                        31'($urandom_range(0, 16777216))});
               write_reg(CSR_MAX_RATE, {1'($urandom_range(0, 1)),
                                        31'($urandom_range(16777216, 50331648))});
            end
         endcase
         @(posedge clock);
         csr_wr_en <= 1'b0;

         base_l = {$urandom_range(0, 255), $urandom};
         base_r = {$urandom_range(0, 255), $urandom};
         if (phase == 1) begin
            // fill past the ring depth so the oldest pair gets pushed out
            for (int k = 0; k < RING_DEPTH + 20; k++) begin
               base_l = base_l + $urandom_range(1, 100000);
               base_r = base_r + $urandom_range(1, 100000);
               send_beat(CMD_SAMPLE, base_r, base_l, 1'b0, '0);
            end
         end
         if (phase == 5) begin
            base_l = TIME_MAX - 64'sd50000000;
            base_r = TIME_MIN + 64'sd50000000;
         end
         for (int k = 0; k < RAND_ITEMS; k++) begin
            if (phase == 4 && k == 40) hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               send_beat(cmd_type'($urandom_range(0, 3)), {$urandom, $urandom},
                         {$urandom, $urandom}, 1'b0, '0);
            end else begin
               pick = $urandom_range(0, 99);
               cmd = pick < 45 ? CMD_SAMPLE : pick < 65 ? CMD_UPDATE :
                     pick < 96 ? CMD_STEP : CMD_CLEAR;
               lstep = $urandom_range(1, 2000000);
               case ($urandom_range(0, 7))
                  0: rstep = lstep * 2;
                  1: rstep = lstep / 4;
                  2: rstep = -lstep;
                  3: rstep = $signed({$urandom_range(0, 15), $urandom});
                  default: rstep = lstep + $signed(64'($urandom_range(0, 2000))) - 1000;
               endcase
               if (cmd == CMD_SAMPLE) begin
                  base_l = add_clip(base_l, lstep);
                  base_r = add_clip(base_r, rstep);
                  send_beat(cmd, base_r, base_l, 1'b0, '0);
               end else begin
                  send_beat(cmd, {$urandom, $urandom},
                            add_clip(base_l, $urandom_range(0, 500000)), 1'b0, '0);
               end
            end
         end
      end

      drain();
      repeat (150) @(posedge clock);
      if (errors == 0 && due_beats.size() == 0) begin
         $display("network_clock_sync_servo_unit_tb: clean");
      end else begin
         $display("network_clock_sync_servo_unit_tb: errors");
      end
      $finish;
   end

endmodule
